### rtl/lpp_pkg.sv
// lpp_pkg: shared constants, types and helpers of the lidar point projection core
// no dependencies; imported by every rtl file of the block except lpp_ram
`timescale 1ns / 1ps

package lpp_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int STORE_DEPTH   = 28;
	localparam int STORE_AW      = 5;
	localparam int PROJ_BASE     = 16;
	localparam int PIX_W         = 12;
	localparam int COLOR_W       = 8;
	localparam int ACC_W         = 2 * DATA_W + 2;
	localparam int QUO_W         = PIX_W + 1;
	localparam int CFG_AW        = 2;
	localparam int CFG_DW        = 12;

	localparam logic [PIX_W-1:0] WIDTH_RESET  = 12'd1392;
	localparam logic [PIX_W-1:0] HEIGHT_RESET = 12'd512;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd1;

	// item operations
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic [1:0] row;
	} mac_ctl_t;

	// clamp a wide dot product to the signed 32-bit range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
		logic [ACC_W-DATA_W:0] upper;
		upper = x[ACC_W-1:DATA_W-1];
		if ((upper == '0) || (upper == '1)) begin
			return x[DATA_W-1:0];
		end else if (x[ACC_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

### rtl/lpp_if.sv
// lpp_if: valid/ready channel interfaces of the projection core (items, results, config)
// depends on lpp_pkg for field widths
`timescale 1ns / 1ps

interface lpp_item_if;
	import lpp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [STORE_AW-1:0]       coef_index;
	logic signed [DATA_W-1:0]  coef_value;
	logic signed [DATA_W-1:0]  point_x;
	logic signed [DATA_W-1:0]  point_y;
	logic signed [DATA_W-1:0]  point_z;
	logic [COLOR_W-1:0]        color_blue;
	logic [COLOR_W-1:0]        color_green;
	logic [COLOR_W-1:0]        color_red;

	modport source (output valid, operation, coef_index, coef_value, point_x, point_y,
		point_z, color_blue, color_green, color_red, input ready);
	modport sink (input valid, operation, coef_index, coef_value, point_x, point_y,
		point_z, color_blue, color_green, color_red, output ready);
endinterface

interface lpp_result_if;
	import lpp_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   pixel_u;
	logic [PIX_W-1:0]   pixel_v;
	logic [COLOR_W-1:0] out_blue;
	logic [COLOR_W-1:0] out_green;
	logic [COLOR_W-1:0] out_red;

	modport source (output valid, pixel_u, pixel_v, out_blue, out_green, out_red,
		input ready);
	modport sink (input valid, pixel_u, pixel_v, out_blue, out_green, out_red,
		output ready);
endinterface

interface lpp_cfg_if;
	import lpp_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_AW-1:0] addr;
	logic [CFG_DW-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

### rtl/lpp_ram.sv
// lpp_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module lpp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 28,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/lpp_mac.sv
// lpp_mac: pipelined signed 32x32 multiply-accumulate, exact 66-bit sum, floored output
// depends on lpp_pkg (mac_ctl_t, widths)
`timescale 1ns / 1ps

module lpp_mac import lpp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctl_t                 ctl,
	input  logic signed [DATA_W-1:0] coef,
	input  logic signed [DATA_W-1:0] vec,
	output logic                     res_valid,
	output logic [1:0]               res_row,
	output logic signed [ACC_W-1:0]  res
);

	mac_ctl_t                   ctl_s1;
	logic signed [2*DATA_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       done_q;
	logic [1:0]                 row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			done_q <= ctl_s1.valid && ctl_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef * vec;
		if (ctl_s1.valid) begin
			acc_q <= (ctl_s1.first ? '0 : acc_q)
				+ {{(ACC_W-2*DATA_W){prod_s1[2*DATA_W-1]}}, prod_s1};
			row_q <= ctl_s1.row;
		end
	end

	assign res_valid = done_q;
	assign res_row   = row_q;
	assign res       = acc_q >>> FRAC_BITS;

endmodule

### rtl/lpp_div.sv
// lpp_div: restoring divider, two numerators over one shared denominator, one bit per cycle
// depends on lpp_pkg for operand and quotient widths
`timescale 1ns / 1ps

module lpp_div import lpp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ACC_W-2:0]   num_u,
	input  logic [ACC_W-2:0]   num_v,
	input  logic [ACC_W-2:0]   den,
	output logic               done,
	output logic [QUO_W-1:0]   q_u,
	output logic [QUO_W-1:0]   q_v
);

	localparam int NUM_W = ACC_W - 1;
	localparam int SH_W  = NUM_W + QUO_W;
	localparam int CNT_W = $clog2(QUO_W);

	logic [SH_W-1:0]  den_q;
	logic [SH_W-1:0]  rem_u_q;
	logic [SH_W-1:0]  rem_v_q;
	logic [QUO_W-1:0] q_u_q;
	logic [QUO_W-1:0] q_v_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge_u;
	logic             ge_v;

	assign ge_u = rem_u_q >= den_q;
	assign ge_v = rem_v_q >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q   <= SH_W'(den) << (QUO_W - 1);
			rem_u_q <= SH_W'(num_u);
			rem_v_q <= SH_W'(num_v);
			q_u_q   <= '0;
			q_v_q   <= '0;
		end else if (busy_q) begin
			// compare against the shifted divisor, one quotient bit per cycle
			if (ge_u) begin
				rem_u_q <= rem_u_q - den_q;
			end
			if (ge_v) begin
				rem_v_q <= rem_v_q - den_q;
			end
			q_u_q <= {q_u_q[QUO_W-2:0], ge_u};
			q_v_q <= {q_v_q[QUO_W-2:0], ge_v};
			den_q <= den_q >> 1;
		end
	end

	assign done = done_q;
	assign q_u  = q_u_q;
	assign q_v  = q_v_q;

endmodule

### rtl/lidar_point_to_pixel_projection_core.sv
// channel   dir  handshake      payload
// item      in   valid/ready    operation, coef_index, coef_value, point xyz, color bgr
// result    out  valid/ready    pixel_u, pixel_v, out_blue, out_green, out_red
// cfg       in   valid/ready    addr (0 width, 1 height), data
//
// a coefficient load does not stall the item channel; a point runs 16 camera MACs and
// 12 projection MACs through one 32x32 multiplier fed from the coefficient ram, then
// the shared restoring divider
// the coefficient ram needs no clearing after reset; width/height reset to 1392/512
// the result register lets the next item in while a pixel waits; a point that finishes
// while the register is still full holds until the sink takes the earlier pixel
//
// top level of the lidar point to pixel projection core
// depends on lpp_pkg, lpp_if, lpp_ram, lpp_mac, lpp_div
`timescale 1ns / 1ps

module lidar_point_to_pixel_projection_core import lpp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	lpp_item_if.sink       item,
	lpp_result_if.source   result,
	lpp_cfg_if.sink        cfg
);

	localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CAM  = 7'b0000010,
		ST_FOV  = 7'b0000100,
		ST_PROJ = 7'b0001000,
		ST_SIGN = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [PIX_W-1:0]         width_q;
	logic [PIX_W-1:0]         height_q;
	logic                     item_acc;
	logic                     ram_we;
	logic                     rd_en;
	logic [DATA_W-1:0]        ram_rdata;
	logic [STORE_AW-1:0]      iss_q;
	logic                     iss_v_s1;
	logic [STORE_AW-1:0]      iss_a_s1;
	logic [1:0]               col;
	mac_ctl_t                 mac_ctl;
	logic signed [DATA_W-1:0] vec;
	logic                     mres_valid;
	logic [1:0]               mres_row;
	logic signed [ACC_W-1:0]  mres;
	logic signed [DATA_W-1:0] px_q;
	logic signed [DATA_W-1:0] py_q;
	logic signed [DATA_W-1:0] pz_q;
	logic [COLOR_W-1:0]       blue_q;
	logic [COLOR_W-1:0]       green_q;
	logic [COLOR_W-1:0]       red_q;
	logic signed [ACC_W-1:0]  cam_q [4];
	logic signed [DATA_W-1:0] cvec_q [4];
	logic signed [ACC_W-1:0]  su_q;
	logic signed [ACC_W-1:0]  sv_q;
	logic signed [ACC_W-1:0]  s_q;
	logic signed [ACC_W-1:0]  cam0_abs;
	logic                     fov_ok;
	logic                     sign_ok;
	logic                     div_start;
	logic                     div_done;
	logic [QUO_W-1:0]         q_u;
	logic [QUO_W-1:0]         q_v;
	logic                     range_ok;
	logic                     emit_load;
	logic                     res_valid_q;
	logic [PIX_W-1:0]         res_u_q;
	logic [PIX_W-1:0]         res_v_q;
	logic [COLOR_W-1:0]       res_blue_q;
	logic [COLOR_W-1:0]       res_green_q;
	logic [COLOR_W-1:0]       res_red_q;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.addr)
				REG_WIDTH: begin
					width_q <= cfg.data[PIX_W-1:0];
				end
				REG_HEIGHT: begin
					height_q <= cfg.data[PIX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// item side
	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign ram_we     = item_acc && (item.operation == OP_LOAD)
		&& (item.coef_index < STORE_AW'(STORE_DEPTH));

	always_ff @(posedge clk) begin
		if (item_acc && (item.operation == OP_PROJECT)) begin
			px_q    <= item.point_x;
			py_q    <= item.point_y;
			pz_q    <= item.point_z;
			blue_q  <= item.color_blue;
			green_q <= item.color_green;
			red_q   <= item.color_red;
		end
	end

	// coefficient reads: camera rows in slots below PROJ_BASE, projection rows from PROJ_BASE up
	assign rd_en = ((state_q == ST_CAM) && (iss_q < STORE_AW'(PROJ_BASE)))
		|| ((state_q == ST_PROJ) && (iss_q < STORE_AW'(STORE_DEPTH)));

	lpp_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_DEPTH),
		.AW    (STORE_AW)
	) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (item.coef_index),
		.wdata (item.coef_value),
		.re    (rd_en),
		.raddr (iss_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q    <= '0;
			iss_v_s1 <= 1'b0;
			iss_a_s1 <= '0;
		end else begin
			iss_v_s1 <= rd_en;
			iss_a_s1 <= iss_q;
			if (item_acc) begin
				iss_q <= '0;
			end else if (rd_en) begin
				iss_q <= iss_q + 1'b1;
			end
		end
	end

	// slot bits [1:0] pick the vector element, [3:2] the matrix row
	assign col = iss_a_s1[1:0];

	always_comb begin
		if (iss_a_s1 >= STORE_AW'(PROJ_BASE)) begin
			vec = cvec_q[col];
		end else begin
			unique case (col)
				2'd0: vec = px_q;
				2'd1: vec = py_q;
				2'd2: vec = pz_q;
				2'd3: vec = ONE_Q;
			endcase
		end
		mac_ctl.valid = iss_v_s1;
		mac_ctl.first = (col == 2'd0);
		mac_ctl.last  = (col == 2'd3);
		mac_ctl.row   = iss_a_s1[3:2];
	end

	lpp_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.coef      (ram_rdata),
		.vec       (vec),
		.res_valid (mres_valid),
		.res_row   (mres_row),
		.res       (mres)
	);

	always_ff @(posedge clk) begin
		if (mres_valid && (state_q == ST_CAM)) begin
			cam_q[mres_row] <= mres;
		end
		if (mres_valid && (state_q == ST_PROJ)) begin
			unique case (mres_row)
				2'd0: su_q <= mres;
				2'd1: sv_q <= mres;
				2'd2: s_q  <= mres;
				default: begin
				end
			endcase
		end
		if (state_q == ST_FOV) begin
			for (int i = 0; i < 4; i++) begin
				cvec_q[i] <= sat32(cam_q[i]);
			end
		end
	end

	// field of view and sign tests
	assign cam0_abs = cam_q[0][ACC_W-1] ? -cam_q[0] : cam_q[0];
	assign fov_ok   = cam_q[2] >= cam0_abs;
	assign sign_ok  = !s_q[ACC_W-1] && (s_q != '0) && !su_q[ACC_W-1] && (su_q != '0)
		&& !sv_q[ACC_W-1] && (sv_q != '0);
	assign div_start = (state_q == ST_SIGN) && sign_ok;

	lpp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_u  (su_q[ACC_W-2:0]),
		.num_v  (sv_q[ACC_W-2:0]),
		.den    (s_q[ACC_W-2:0]),
		.done   (div_done),
		.q_u    (q_u),
		.q_v    (q_v)
	);

	assign range_ok  = (q_u < {1'b0, width_q}) && (q_v < {1'b0, height_q});
	assign emit_load = (state_q == ST_EMIT) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc && (item.operation == OP_PROJECT)) begin
						state_q <= ST_CAM;
					end
				end
				ST_CAM: begin
					if (mres_valid && (mres_row == 2'd3)) begin
						state_q <= ST_FOV;
					end
				end
				ST_FOV: begin
					state_q <= fov_ok ? ST_PROJ : ST_IDLE;
				end
				ST_PROJ: begin
					if (mres_valid && (mres_row == 2'd2)) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					state_q <= sign_ok ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= range_ok ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_u_q     <= q_u[PIX_W-1:0];
			res_v_q     <= q_v[PIX_W-1:0];
			res_blue_q  <= blue_q;
			res_green_q <= green_q;
			res_red_q   <= red_q;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.pixel_u   = res_u_q;
	assign result.pixel_v   = res_v_q;
	assign result.out_blue  = res_blue_q;
	assign result.out_green = res_green_q;
	assign result.out_red   = res_red_q;

endmodule

### rtl/lpp_checker.sv
// lpp_checker: port-level assertions for the projection core, bound to the top level
// depends on lpp_pkg and lidar_point_to_pixel_projection_core
`timescale 1ns / 1ps

module lpp_checker import lpp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic item_operation,
	input logic result_valid,
	input logic result_ready,
	input logic cfg_ready
);

	// a pending pixel stays offered until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result transaction dropped before it was taken");

	// a point transaction occupies the datapath
	a_point_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_operation == OP_PROJECT) |=> !item_ready)
		else $error("item accepted while a point is in flight");

	// a coefficient load does not stall the item channel
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_operation == OP_LOAD) |=> item_ready)
		else $error("coefficient load stalled the item channel");

	// a new pixel only appears after the busy period of its point
	a_pixel_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("pixel appeared without a point in flight");

	// configuration writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel stalled");

endmodule

bind lidar_point_to_pixel_projection_core lpp_checker u_lpp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_operation (item.operation),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.cfg_ready      (cfg.ready)
);

### tb/sv/tb_top.sv
// tb_top: self-checking bench for the lidar point to pixel projection core
// depends on lpp_pkg, lpp_if and the core; a queue-fed driver and a clocked monitor
// check every pixel against an in-bench fixed point projection predictor
`timescale 1ns / 1ps

module tb_top;
	import lpp_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int CLK_HALF = 10;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 80;
	localparam logic [31:0] ONE_Q = 32'd1 << FRAC;
	localparam logic [31:0] Z10 = 32'd10 << FRAC;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

	typedef struct packed {
		logic                hold;
		logic                op;
		logic [STORE_AW-1:0] idx;
		logic [DATA_W-1:0]   cval;
		logic [DATA_W-1:0]   x;
		logic [DATA_W-1:0]   y;
		logic [DATA_W-1:0]   z;
		logic [COLOR_W-1:0]  blue;
		logic [COLOR_W-1:0]  green;
		logic [COLOR_W-1:0]  red;
	} stim_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_u;
		logic [PIX_W-1:0]   pixel_v;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stim_t             cur = '0;
	logic              it_valid = 1'b0;
	logic              cf_valid = 1'b0;
	logic [CFG_AW-1:0] cf_addr = '0;
	logic [CFG_DW-1:0] cf_data = '0;
	logic              rs_ready = 1'b0;

	stim_t  stim_q [$];
	pixel_t pixel_q [$];

	// predictor copy of the block state
	logic [DATA_W-1:0] coef_mem [STORE_DEPTH];
	logic [PIX_W-1:0]  width_reg = WIDTH_RESET;
	logic [PIX_W-1:0]  height_reg = HEIGHT_RESET;

	// scene the stimulus is built around
	logic [DATA_W-1:0] scene [STORE_DEPTH];
	int focal_px = 700;
	int half_h = 256;

	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	lpp_item_if   item_ch ();
	lpp_result_if pix_ch ();
	lpp_cfg_if    cfg_ch ();

	assign item_ch.valid       = it_valid;
	assign item_ch.operation   = cur.op;
	assign item_ch.coef_index  = cur.idx;
	assign item_ch.coef_value  = cur.cval;
	assign item_ch.point_x     = cur.x;
	assign item_ch.point_y     = cur.y;
	assign item_ch.point_z     = cur.z;
	assign item_ch.color_blue  = cur.blue;
	assign item_ch.color_green = cur.green;
	assign item_ch.color_red   = cur.red;
	assign cfg_ch.valid        = cf_valid;
	assign cfg_ch.addr         = cf_addr;
	assign cfg_ch.data         = cf_data;
	assign pix_ch.ready        = rs_ready;

	lidar_point_to_pixel_projection_core #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(pix_ch),
		.cfg(cfg_ch)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [127:0] store_row(input int base);
		return {coef_mem[base + 3], coef_mem[base + 2], coef_mem[base + 1], coef_mem[base]};
	endfunction

	// exact four-term dot product, floored to FRAC fraction bits
	function automatic logic signed [63:0] dot_floor(input logic [127:0] w,
		input logic [127:0] v);
		logic signed [79:0] acc;
		logic signed [79:0] prod;
		logic signed [31:0] a;
		logic signed [31:0] b;
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			a = w[32*k +: 32];
			b = v[32*k +: 32];
			prod = a * b;
			acc = acc + prod;
		end
		acc = acc >>> FRAC;
		return acc[63:0];
	endfunction

	function automatic logic [31:0] clamp32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return INT_MAX;
		if (x < -64'sd2147483648)
			return INT_MIN;
		return x[31:0];
	endfunction

	function automatic bit project_point(input stim_t it, output pixel_t px);
		logic signed [63:0] cam0, cam1, cam2, cam3;
		logic signed [63:0] mag, su, sv, sw, qu, qv, wlim, hlim;
		logic [127:0] pvec, cvec;
		px = '0;
		pvec = {ONE_Q, it.z, it.y, it.x};
		cam0 = dot_floor(store_row(0), pvec);
		cam1 = dot_floor(store_row(4), pvec);
		cam2 = dot_floor(store_row(8), pvec);
		cam3 = dot_floor(store_row(12), pvec);
		// field of view: keep only cz >= |cx|
		mag = (cam0 < 0) ? -cam0 : cam0;
		if (cam2 < mag)
			return 1'b0;
		cvec = {clamp32(cam3), clamp32(cam2), clamp32(cam1), clamp32(cam0)};
		su = dot_floor(store_row(PROJ_BASE), cvec);
		sv = dot_floor(store_row(PROJ_BASE + 4), cvec);
		sw = dot_floor(store_row(PROJ_BASE + 8), cvec);
		if (sw <= 0 || su <= 0 || sv <= 0)
			return 1'b0;
		qu = su / sw;
		qv = sv / sw;
		wlim = {52'd0, width_reg};
		hlim = {52'd0, height_reg};
		if (qu >= wlim || qv >= hlim)
			return 1'b0;
		px.pixel_u = qu[PIX_W-1:0];
		px.pixel_v = qv[PIX_W-1:0];
		px.blue = it.blue;
		px.green = it.green;
		px.red = it.red;
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin : item_driver
		stim_t nxt;
		pixel_t px;
		if (!arst_n) begin
			it_valid <= 1'b0;
		end else begin
			if (it_valid && item_ch.ready) begin
				if (cur.op == OP_LOAD) begin
					if (cur.idx < STORE_DEPTH)
						coef_mem[cur.idx] = cur.cval;
				end else if (project_point(cur, px)) begin
					pixel_q = {pixel_q, px};
				end
			end
			if (!it_valid || item_ch.ready) begin
				if (stim_q.size() != 0 && $urandom_range(99) >= send_gap_pct &&
						!(stim_q[0].hold && pixel_q.size() != 0)) begin
					nxt = stim_q.pop_front();
					cur <= nxt;
					it_valid <= 1'b1;
				end else begin
					it_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		if (fail_count < 100)
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what,
				got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : pixel_monitor
		pixel_t want;
		if (!arst_n) begin
			rs_ready <= 1'b0;
		end else begin
			if (pix_ch.valid && rs_ready) begin
				if (pixel_q.size() == 0) begin
					report_mismatch("unexpected pixel, u", pix_ch.pixel_u, 0);
				end else begin
					want = pixel_q.pop_front();
					if (pix_ch.pixel_u !== want.pixel_u)
						report_mismatch("pixel_u", pix_ch.pixel_u, want.pixel_u);
					if (pix_ch.pixel_v !== want.pixel_v)
						report_mismatch("pixel_v", pix_ch.pixel_v, want.pixel_v);
					if (pix_ch.out_blue !== want.blue)
						report_mismatch("out_blue", pix_ch.out_blue, want.blue);
					if (pix_ch.out_green !== want.green)
						report_mismatch("out_green", pix_ch.out_green, want.green);
					if (pix_ch.out_red !== want.red)
						report_mismatch("out_red", pix_ch.out_red, want.red);
				end
			end
			rs_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic int jitter(input int m);
		return int'($urandom_range(2 * m)) - m;
	endfunction

	task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
		@(posedge clk);
		cf_valid <= 1'b1;
		cf_addr <= addr;
		cf_data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cf_valid <= 1'b0;
		if (addr == REG_WIDTH)
			width_reg = data;
		else if (addr == REG_HEIGHT)
			height_reg = data;
	endtask

	task automatic push_load(input int idx, input logic [31:0] val);
		stim_t s;
		s.hold = 1'b0;
		s.op = OP_LOAD;
		s.idx = STORE_AW'(idx);
		s.cval = val;
		s.x = $urandom;
		s.y = $urandom;
		s.z = $urandom;
		{s.blue, s.green, s.red} = 24'($urandom);
		stim_q = {stim_q, s};
	endtask

	task automatic push_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
		input int unsigned bgr, input bit hold);
		stim_t s;
		s.hold = hold;
		s.op = OP_PROJECT;
		s.idx = STORE_AW'($urandom);
		s.cval = $urandom;
		s.x = x;
		s.y = y;
		s.z = z;
		{s.blue, s.green, s.red} = 24'(bgr);
		stim_q = {stim_q, s};
	endtask

	// point in front of the camera, mostly inside the view and the image
	task automatic push_scene_point(input bit hold);
		longint zq, xl, yl, xv, yv;
		zq = $urandom_range(80 << FRAC, 1 << (FRAC - 1));
		xl = zq + zq / 8;
		yl = zq * (half_h + 8) * 5 / (4 * focal_px);
		if (yl > (1 << 30))
			yl = 1 << 30;
		xv = longint'($urandom_range(2 * xl)) - xl;
		yv = longint'($urandom_range(2 * yl)) - yl;
		push_point(xv[31:0], yv[31:0], zq[31:0], $urandom, hold);
	endtask

	task automatic make_scene(input int w, input int h, input bit wild);
		int r, c;
		focal_px = ((w < 32) ? 32 : w) / 2 * $urandom_range(120, 80) / 100;
		half_h = h / 2;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			r = i / 4;
			c = i % 4;
			if (wild)
				scene[i] = ($urandom_range(3) == 0) ? $urandom : jitter(1 << (FRAC + 2));
			else if (i >= PROJ_BASE)
				scene[i] = '0;
			else if (r == 3)
				scene[i] = (c == 3) ? ONE_Q : '0;
			else if (c == r)
				scene[i] = ONE_Q + jitter(ONE_Q / 20);
			else if (c == 3)
				scene[i] = jitter(2 << FRAC);
			else
				scene[i] = jitter(ONE_Q / 20);
		end
		if (!wild) begin
			scene[PROJ_BASE] = focal_px << FRAC;
			scene[PROJ_BASE + 2] = (w / 2) << FRAC;
			scene[PROJ_BASE + 3] = focal_px * jitter(ONE_Q / 10);
			scene[PROJ_BASE + 5] = focal_px << FRAC;
			scene[PROJ_BASE + 6] = half_h << FRAC;
			scene[PROJ_BASE + 10] = ONE_Q;
		end
	endtask

	// whole store in shuffled order, with loads to indexes past the store mixed in
	task automatic load_store();
		int order [STORE_DEPTH];
		int j, t;
		for (int i = 0; i < STORE_DEPTH; i++)
			order[i] = i;
		for (int i = STORE_DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < STORE_DEPTH; i++) begin
			push_load(order[i], scene[order[i]]);
			if (i == 9 || i == 20)
				push_load($urandom_range(31, STORE_DEPTH), $urandom);
		end
	endtask

	task automatic run_random(input int n, input bit wild);
		int roll, idx;
		logic [31:0] val;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 3) begin
				idx = $urandom_range(STORE_DEPTH - 1);
				val = scene[idx] + jitter(4096);
				scene[idx] = val;
				push_load(idx, val);
			end else if (roll < 5) begin
				push_load($urandom_range(31, STORE_DEPTH), $urandom);
			end else if (wild || roll < 15) begin
				push_point($urandom, $urandom, $urandom, $urandom, $urandom_range(99) == 0);
			end else begin
				push_scene_point($urandom_range(99) == 0);
			end
		end
	endtask

	// wait for the queue and every pending pixel, then let a point in flight finish
	task automatic drain();
		@(negedge clk);
		while (stim_q.size() != 0 || it_valid || pixel_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int w, input int h, input int n, input bit wild);
		write_reg(REG_WIDTH, w[CFG_DW-1:0]);
		write_reg(REG_HEIGHT, h[CFG_DW-1:0]);
		make_scene(w, h, wild);
		load_store();
		run_random(n, wild);
		drain();
	endtask

	initial begin
		for (int i = 0; i < STORE_DEPTH; i++)
			coef_mem[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send_gap_pct = 14;
		recv_stall_pct = 83;

		// directed: identity camera, square pixels of 700, center (696, 256)
		write_reg(REG_WIDTH, WIDTH_RESET);
		write_reg(REG_HEIGHT, HEIGHT_RESET);
		for (int i = 0; i < STORE_DEPTH; i++)
			scene[i] = '0;
		scene[0] = ONE_Q;
		scene[5] = ONE_Q;
		scene[10] = ONE_Q;
		scene[15] = ONE_Q;
		scene[PROJ_BASE] = 700 << FRAC;
		scene[PROJ_BASE + 2] = 696 << FRAC;
		scene[PROJ_BASE + 5] = 700 << FRAC;
		scene[PROJ_BASE + 6] = 256 << FRAC;
		scene[PROJ_BASE + 10] = ONE_Q;
		load_store();
		push_point('0, '0, Z10, 24'h000000, 1'b0);
		push_point('0, '0, Z10, 24'hffffff, 1'b0);
		// column quotient between zero and one
		push_point(-(1391 << (FRAC - 1)), '0, 700 << FRAC, $urandom, 1'b1);
		// row quotient between zero and one
		push_point('0, -(511 << (FRAC - 1)), 700 << FRAC, $urandom, 1'b0);
		push_point(Z10, '0, Z10, $urandom, 1'b0);
		push_point(Z10 + 1, '0, Z10, $urandom, 1'b0);
		push_point('0, '0, '0, $urandom, 1'b0);
		push_point(-Z10, '0, Z10, $urandom, 1'b0);
		push_point(INT_MIN, INT_MAX, INT_MAX, $urandom, 1'b0);
		push_point(INT_MAX, INT_MIN, INT_MAX, $urandom, 1'b0);
		push_point('0, '0, INT_MIN, $urandom, 1'b0);
		// camera depth saturates
		push_load(10, INT_MAX);
		push_point('0, '0, INT_MAX, $urandom, 1'b0);
		push_point(ONE_Q, ONE_Q, 32'd1 << (FRAC + 4), $urandom, 1'b0);
		push_load(10, ONE_Q);
		push_load(7, INT_MIN);
		push_point('0, '0, Z10, $urandom, 1'b0);
		push_load(7, INT_MAX);
		push_point('0, '0, Z10, $urandom, 1'b0);
		push_load(7, '0);
		push_load(STORE_DEPTH, $urandom);
		push_load(31, $urandom);
		push_point('0, '0, Z10, $urandom, 1'b0);
		drain();

		run_phase(WIDTH_RESET, HEIGHT_RESET, 280, 1'b0);
		run_phase(4095, 4095, 250, 1'b0);

		send_gap_pct = 83;
		recv_stall_pct = 14;
		run_phase(1, 1, 60, 1'b0);
		run_phase(640, 480, 300, 1'b0);
		run_phase(0, 200, 40, 1'b0);
		run_phase(WIDTH_RESET, HEIGHT_RESET, 100, 1'b1);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		run_phase($urandom_range(4095, 64), $urandom_range(4095, 64), 265, 1'b0);
		run_phase($urandom_range(4095, 64), $urandom_range(4095, 64), 265, 1'b0);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
